/* hw/rtl/lfed_pkg.sv */
// Shared types and constants of the length-framed event deframer.
package lfed_pkg;

  // Framing and opcode bytes.
  localparam logic [7:0] START_BYTE    = 8'hAA;
  localparam logic [7:0] OPC_ACK       = 8'h00;
  localparam logic [7:0] OPC_LE_SIGNAL = 8'h32;

  // Width of the payload count field.
  localparam int unsigned COUNT_W = 7;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_LE      = 2'd1,
    KIND_UNKNOWN = 2'd2,
    KIND_BADSUM  = 2'd3
  } kind_e;

  // Position of the deframer inside a frame.
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_BODY   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_e;

  // Control sequencer: take bytes, or replay the payload store.
  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_EMIT_RD = 2'd1,
    ST_EMIT_WR = 2'd2
  } ctrl_e;

endpackage

/* hw/rtl/lfed_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module lfed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data is registered and appears in the cycle after the read request.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/length_framed_event_deframer.sv */
// Top level of the length-framed event deframer.
//
// The block takes one link byte per request and looks for frames of the form
// start byte 0xAA, 16-bit big-endian body length, body, checksum byte; a frame
// is good when every byte after the start byte sums to zero modulo 256. The
// checksum byte produces the results: one result for an acknowledge, an
// unknown opcode, a bad sum or an LE signalling event with no payload. For an
// LE signalling event with N stored payload bytes, the payload is read back
// from the payload RAM and one result per byte is shown, each by a RAM read
// and then an output register load that waits for the output register to
// free up, so input is held off until the last payload byte has been shown.
// Payload bytes beyond PAYLOAD_DEPTH are dropped and flagged as truncated. The
// output register lets ordinary bytes keep flowing while a result waits to be
// taken; only a checksum byte waits for the output register to free up.
module length_framed_event_deframer #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  opcode_o,
  output logic [15:0] frame_length_o,
  output logic [7:0]  ack_cmd_o,
  output logic [7:0]  ack_status_o,
  output logic [7:0]  sub_event_o,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic [6:0]  payload_count_o,
  output logic        truncated_o,
  output logic        last_o
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [lfed_pkg::COUNT_W-1:0] DEPTH_CNT = lfed_pkg::COUNT_W'(PAYLOAD_DEPTH);

  // Frame state.
  lfed_pkg::phase_e phase_q, phase_d;
  lfed_pkg::ctrl_e  st_q, st_d;
  logic [15:0] len_q, len_d;
  logic [15:0] idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  opc_q, opc_d;
  logic [7:0]  par1_q, par1_d;
  logic [7:0]  par2_q, par2_d;
  logic [lfed_pkg::COUNT_W-1:0] fill_q, fill_d;
  logic [lfed_pkg::COUNT_W-1:0] rd_idx_q, rd_idx_d;
  logic ovf_q, ovf_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  lfed_pkg::kind_e  kind_q, kind_d;
  logic [7:0]       opcode_q, opcode_d;
  logic [15:0]      flen_q, flen_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       status_q, status_d;
  logic [7:0]       sub_q, sub_d;
  logic [7:0]       pbyte_q, pbyte_d;
  logic             pvalid_q, pvalid_d;
  logic [6:0]       pcount_q, pcount_d;
  logic             trunc_q, trunc_d;
  logic             last_q, last_d;
  logic             out_load;

  // Payload RAM access.
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  logic          in_acc;
  logic          out_free;
  logic [7:0]    sum_next;
  logic [15:0]   idx_next;
  logic [15:0]   len_full;
  logic [lfed_pkg::COUNT_W-1:0] rd_idx_next;
  logic          rd_last;

  lfed_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Handshake qualifiers.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (st_q != lfed_pkg::ST_RUN) ||
                      ((phase_q == lfed_pkg::PH_CHECK) && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign sum_next    = sum_q + rx_byte_i;
  assign idx_next    = idx_q + 16'd1;
  assign len_full    = {len_q[15:8], rx_byte_i};
  assign rd_idx_next = rd_idx_q + lfed_pkg::COUNT_W'(1);
  assign rd_last     = (rd_idx_next == fill_q);

  // Frame parsing, result selection and payload replay.
  always_comb begin
    phase_d  = phase_q;
    st_d     = st_q;
    len_d    = len_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    opc_d    = opc_q;
    par1_d   = par1_q;
    par2_d   = par2_q;
    fill_d   = fill_q;
    rd_idx_d = rd_idx_q;
    ovf_d    = ovf_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;

    kind_d   = lfed_pkg::KIND_UNKNOWN;
    opcode_d = opc_q;
    flen_d   = len_q;
    cmd_d    = 8'h00;
    status_d = 8'h00;
    sub_d    = 8'h00;
    pbyte_d  = 8'h00;
    pvalid_d = 1'b0;
    pcount_d = 7'd0;
    trunc_d  = 1'b0;
    last_d   = 1'b1;

    case (st_q)
      lfed_pkg::ST_RUN: begin
        if (in_acc) begin
          case (phase_q)
            lfed_pkg::PH_LEN_HI: begin
              sum_d   = sum_next;
              len_d   = {rx_byte_i, 8'h00};
              phase_d = lfed_pkg::PH_LEN_LO;
            end
            lfed_pkg::PH_LEN_LO: begin
              sum_d   = sum_next;
              len_d   = len_full;
              phase_d = (len_full == 16'd0) ? lfed_pkg::PH_CHECK : lfed_pkg::PH_BODY;
            end
            lfed_pkg::PH_BODY: begin
              sum_d = sum_next;
              // The first three body bytes are the header; the rest is payload.
              if (idx_q == 16'd0) begin
                opc_d = rx_byte_i;
              end else if (idx_q == 16'd1) begin
                par1_d = rx_byte_i;
              end else if (idx_q == 16'd2) begin
                par2_d = rx_byte_i;
              end else if (fill_q < DEPTH_CNT) begin
                ram_we = 1'b1;
                fill_d = fill_q + lfed_pkg::COUNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
              idx_d = idx_next;
              if (idx_next == len_q) begin
                phase_d = lfed_pkg::PH_CHECK;
              end
            end
            lfed_pkg::PH_CHECK: begin
              sum_d    = sum_next;
              phase_d  = lfed_pkg::PH_HUNT;
              out_load = 1'b1;
              if (sum_next != 8'h00) begin
                kind_d = lfed_pkg::KIND_BADSUM;
              end else if (opc_q == lfed_pkg::OPC_ACK) begin
                kind_d   = lfed_pkg::KIND_ACK;
                cmd_d    = par1_q;
                status_d = par2_q;
              end else if (opc_q == lfed_pkg::OPC_LE_SIGNAL) begin
                kind_d  = lfed_pkg::KIND_LE;
                sub_d   = par1_q;
                trunc_d = ovf_q;
                if (fill_q != '0) begin
                  // Payload present: replay it from the RAM instead.
                  out_load = 1'b0;
                  rd_idx_d = '0;
                  st_d     = lfed_pkg::ST_EMIT_RD;
                end
              end else begin
                kind_d = lfed_pkg::KIND_UNKNOWN;
              end
            end
            default: begin
              phase_d = lfed_pkg::PH_HUNT;
              if (rx_byte_i == lfed_pkg::START_BYTE) begin
                phase_d = lfed_pkg::PH_LEN_HI;
                len_d   = 16'd0;
                idx_d   = 16'd0;
                sum_d   = 8'h00;
                opc_d   = 8'h00;
                par1_d  = 8'h00;
                par2_d  = 8'h00;
                fill_d  = '0;
                ovf_d   = 1'b0;
              end
            end
          endcase
        end
      end
      lfed_pkg::ST_EMIT_RD: begin
        ram_re = 1'b1;
        st_d   = lfed_pkg::ST_EMIT_WR;
      end
      lfed_pkg::ST_EMIT_WR: begin
        // Read data is held in the RAM until the output register frees up.
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = lfed_pkg::KIND_LE;
          sub_d    = par1_q;
          pbyte_d  = ram_rdata;
          pvalid_d = 1'b1;
          pcount_d = fill_q;
          trunc_d  = ovf_q;
          last_d   = rd_last;
          rd_idx_d = rd_idx_next;
          st_d     = rd_last ? lfed_pkg::ST_RUN : lfed_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        st_d = lfed_pkg::ST_RUN;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  // Control and frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lfed_pkg::PH_HUNT;
      st_q        <= lfed_pkg::ST_RUN;
      len_q       <= 16'd0;
      idx_q       <= 16'd0;
      sum_q       <= 8'h00;
      opc_q       <= 8'h00;
      par1_q      <= 8'h00;
      par2_q      <= 8'h00;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      st_q        <= st_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      opc_q       <= opc_d;
      par1_q      <= par1_d;
      par2_q      <= par2_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q   <= kind_d;
      opcode_q <= opcode_d;
      flen_q   <= flen_d;
      cmd_q    <= cmd_d;
      status_q <= status_d;
      sub_q    <= sub_d;
      pbyte_q  <= pbyte_d;
      pvalid_q <= pvalid_d;
      pcount_q <= pcount_d;
      trunc_q  <= trunc_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign opcode_o        = opcode_q;
  assign frame_length_o  = flen_q;
  assign ack_cmd_o       = cmd_q;
  assign ack_status_o    = status_q;
  assign sub_event_o     = sub_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_valid_o = pvalid_q;
  assign payload_count_o = pcount_q;
  assign truncated_o     = trunc_q;
  assign last_o          = last_q;

`ifndef NO_ASSERTIONS
  // Replay only runs for a frame that stored payload.
  a_emit_has_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != lfed_pkg::ST_RUN) |-> (fill_q != '0))
    else $error("payload replay with an empty payload store");

  // The replay index stays inside the stored payload.
  a_rd_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != lfed_pkg::ST_RUN) |-> (rd_idx_q < fill_q))
    else $error("payload replay index past the fill count");

  // The fill count never exceeds the store depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_CNT)
    else $error("payload fill count above store depth");

  // The final replayed result returns the block to taking bytes.
  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == lfed_pkg::ST_EMIT_WR && out_load && rd_last) |=> (st_q == lfed_pkg::ST_RUN))
    else $error("replay did not finish after its last result");

  // A result that waits is not overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("output register loaded while its result waits");
`endif

endmodule

/* dv/length_framed_event_deframer_test.sv */
// Self-checking testbench of the length-framed event deframer.
module length_framed_event_deframer_test;

  localparam int PAY_DEPTH     = 64;
  localparam int TOTAL_BYTES   = 380;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 150;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 100000;

  // One result of the block, field by field.
  typedef struct packed {
    lfed_pkg::kind_e kind;
    logic [7:0]  opcode;
    logic [15:0] frame_length;
    logic [7:0]  ack_cmd;
    logic [7:0]  ack_status;
    logic [7:0]  sub_event;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [6:0]  payload_count;
    logic        truncated;
    logic        last;
  } frame_result_t;

  // One row of stimulus; a checked row carries its result typed in by hand.
  typedef struct {
    logic [7:0]    rx;
    bit            checked;
    frame_result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  opcode_o;
  logic [15:0] frame_length_o;
  logic [7:0]  ack_cmd_o;
  logic [7:0]  ack_status_o;
  logic [7:0]  sub_event_o;
  logic [7:0]  payload_byte_o;
  logic        payload_valid_o;
  logic [6:0]  payload_count_o;
  logic        truncated_o;
  logic        last_o;

  length_framed_event_deframer #(
    .PAYLOAD_DEPTH(PAY_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .opcode_o       (opcode_o),
    .frame_length_o (frame_length_o),
    .ack_cmd_o      (ack_cmd_o),
    .ack_status_o   (ack_status_o),
    .sub_event_o    (sub_event_o),
    .payload_byte_o (payload_byte_o),
    .payload_valid_o(payload_valid_o),
    .payload_count_o(payload_count_o),
    .truncated_o    (truncated_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state, a private copy of the deframer's registers.
  lfed_pkg::phase_e fr_phase = lfed_pkg::PH_HUNT;
  logic [15:0] hdr_len = '0;
  logic [15:0] body_pos = '0;
  logic [7:0]  csum = '0;
  logic [7:0]  op_byte = '0;
  logic [7:0]  param1 = '0;
  logic [7:0]  param2 = '0;
  logic [7:0]  pay_mem [PAY_DEPTH];
  logic [6:0]  pay_fill = '0;
  logic        dropped = 1'b0;

  frame_result_t new_results[$];
  frame_result_t pending_results[$];
  stim_row_t     stim_rows[$];
  int            fail_count = 0;
  int            accepted_bytes = 0;
  int            cycle_count = 0;

  function automatic frame_result_t pack_result(
    input lfed_pkg::kind_e kind, input logic [7:0] opc, input logic [15:0] len,
    input logic [7:0] cmd, input logic [7:0] status, input logic [7:0] sub,
    input logic [7:0] pbyte, input logic pvalid, input logic [6:0] pcount,
    input logic trunc, input logic fin);
    frame_result_t r;
    r.kind          = kind;
    r.opcode        = opc;
    r.frame_length  = len;
    r.ack_cmd       = cmd;
    r.ack_status    = status;
    r.sub_event     = sub;
    r.payload_byte  = pbyte;
    r.payload_valid = pvalid;
    r.payload_count = pcount;
    r.truncated     = trunc;
    r.last          = fin;
    return r;
  endfunction

  // Advance the predictor by one link byte; the results it causes go to new_results.
  task automatic deframe_byte(input logic [7:0] rx);
    case (fr_phase)
      lfed_pkg::PH_LEN_HI: begin
        csum     = csum + rx;
        hdr_len  = {rx, 8'h00};
        fr_phase = lfed_pkg::PH_LEN_LO;
      end
      lfed_pkg::PH_LEN_LO: begin
        csum         = csum + rx;
        hdr_len[7:0] = rx;
        fr_phase     = (hdr_len == 16'd0) ? lfed_pkg::PH_CHECK : lfed_pkg::PH_BODY;
      end
      lfed_pkg::PH_BODY: begin
        csum = csum + rx;
        if (body_pos == 16'd0) begin
          op_byte = rx;
        end else if (body_pos == 16'd1) begin
          param1 = rx;
        end else if (body_pos == 16'd2) begin
          param2 = rx;
        end else if (pay_fill < PAY_DEPTH) begin
          pay_mem[pay_fill[5:0]] = rx;
          pay_fill = pay_fill + 7'd1;
        end else begin
          dropped = 1'b1;
        end
        body_pos = body_pos + 16'd1;
        if (body_pos == hdr_len) fr_phase = lfed_pkg::PH_CHECK;
      end
      lfed_pkg::PH_CHECK: begin
        csum = csum + rx;
        if (csum != 8'h00) begin
          new_results.push_back(pack_result(lfed_pkg::KIND_BADSUM, op_byte, hdr_len,
                                            8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 7'd0,
                                            1'b0, 1'b1));
        end else if (op_byte == lfed_pkg::OPC_ACK) begin
          new_results.push_back(pack_result(lfed_pkg::KIND_ACK, op_byte, hdr_len,
                                            param1, param2, 8'h00, 8'h00, 1'b0, 7'd0,
                                            1'b0, 1'b1));
        end else if (op_byte == lfed_pkg::OPC_LE_SIGNAL) begin
          if (pay_fill == 7'd0) begin
            new_results.push_back(pack_result(lfed_pkg::KIND_LE, op_byte, hdr_len,
                                              8'h00, 8'h00, param1, 8'h00, 1'b0, 7'd0,
                                              dropped, 1'b1));
          end else begin
            for (int i = 0; i < int'(pay_fill); i++) begin
              new_results.push_back(pack_result(lfed_pkg::KIND_LE, op_byte, hdr_len,
                                                8'h00, 8'h00, param1, pay_mem[6'(i)],
                                                1'b1, pay_fill, dropped,
                                                i + 1 == int'(pay_fill)));
            end
          end
        end else begin
          new_results.push_back(pack_result(lfed_pkg::KIND_UNKNOWN, op_byte, hdr_len,
                                            8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 7'd0,
                                            1'b0, 1'b1));
        end
        fr_phase = lfed_pkg::PH_HUNT;
      end
      default: begin
        fr_phase = lfed_pkg::PH_HUNT;
        if (rx == lfed_pkg::START_BYTE) begin
          hdr_len  = '0;
          body_pos = '0;
          csum     = '0;
          op_byte  = '0;
          param1   = '0;
          param2   = '0;
          pay_fill = '0;
          dropped  = 1'b0;
          fr_phase = lfed_pkg::PH_LEN_HI;
        end
      end
    endcase
  endtask

  task automatic add_row(input logic [7:0] rx);
    stim_row_t row;
    row.rx      = rx;
    row.checked = 1'b0;
    row.want    = '0;
    stim_rows.push_back(row);
  endtask

  task automatic add_checked_row(input logic [7:0] rx, input frame_result_t want);
    stim_row_t row;
    row.rx      = rx;
    row.checked = 1'b1;
    row.want    = want;
    stim_rows.push_back(row);
  endtask

  // Append one random frame, or a little noise; a negative length picks one at random.
  task automatic add_random_frame(input int forced_len);
    logic [7:0]  rx;
    logic [7:0]  opc;
    logic [7:0]  sum;
    logic [15:0] declared;
    int          len;
    int          pick;
    if (forced_len < 0 && $urandom_range(0, 99) < 8) begin
      // Noise between frames; a start byte here would open a frame of random length.
      repeat ($urandom_range(1, 4)) begin
        rx = 8'($urandom);
        if (rx == lfed_pkg::START_BYTE) rx = 8'h55;
        add_row(rx);
      end
    end else begin
      if (forced_len >= 0) len = forced_len;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
      else len = $urandom_range(0, 12);
      pick = $urandom_range(0, 99);
      if (forced_len >= 0 || (pick >= 25 && pick < 70)) opc = lfed_pkg::OPC_LE_SIGNAL;
      else if (pick < 25) opc = lfed_pkg::OPC_ACK;
      else opc = 8'($urandom);
      // Now and then the header claims more body than is sent.
      declared = 16'(len);
      if (forced_len < 0 && $urandom_range(0, 19) == 0)
        declared = 16'(len + $urandom_range(1, 6));
      add_row(lfed_pkg::START_BYTE);
      add_row(declared[15:8]);
      add_row(declared[7:0]);
      sum = declared[15:8] + declared[7:0];
      for (int k = 0; k < len; k++) begin
        rx = (k == 0) ? opc : 8'($urandom);
        add_row(rx);
        sum = sum + rx;
      end
      if ($urandom_range(0, 99) < 85) add_row(8'h00 - sum);
      else add_row(8'($urandom));
    end
  endtask

  task automatic flag_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    fail_count++;
    $error("%s: expected %0d, actual %0d", field, want, got);
  endtask

  // Cycle limit for the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: a long hold once the stream is under way, otherwise a changing stall pattern.
  always @(posedge clk_i) begin : result_stall
    int rx_tick;
    int hold_left;
    bit hold_done;
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && accepted_bytes >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      case ((rx_tick / 97) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 99) < 30);
        2: out_stall_i <= ((rx_tick % 5) < 3);
        default: out_stall_i <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, kind", 0, kind_o);
      end else begin
        want = pending_results.pop_front();
        if (want.kind !== kind_o) flag_mismatch("kind", want.kind, kind_o);
        if (want.opcode !== opcode_o) flag_mismatch("opcode", want.opcode, opcode_o);
        if (want.frame_length !== frame_length_o)
          flag_mismatch("frame_length", want.frame_length, frame_length_o);
        if (want.ack_cmd !== ack_cmd_o)
          flag_mismatch("ack_cmd", want.ack_cmd, ack_cmd_o);
        if (want.ack_status !== ack_status_o)
          flag_mismatch("ack_status", want.ack_status, ack_status_o);
        if (want.sub_event !== sub_event_o)
          flag_mismatch("sub_event", want.sub_event, sub_event_o);
        if (want.payload_byte !== payload_byte_o)
          flag_mismatch("payload_byte", want.payload_byte, payload_byte_o);
        if (want.payload_valid !== payload_valid_o)
          flag_mismatch("payload_valid", want.payload_valid, payload_valid_o);
        if (want.payload_count !== payload_count_o)
          flag_mismatch("payload_count", want.payload_count, payload_count_o);
        if (want.truncated !== truncated_o)
          flag_mismatch("truncated", want.truncated, truncated_o);
        if (want.last !== last_o) flag_mismatch("last", want.last, last_o);
      end
    end
  end

  // Stimulus and sender.
  initial begin
    int directed_rows;
    int pause_row;
    int frame_no;
    int burst_left;

    // Directed frames.
    add_row(8'h55);                         // Ignored while hunting.
    // Zero-length body reads as an acknowledge of command 0.
    add_row(lfed_pkg::START_BYTE); add_row(8'h00); add_row(8'h00);
    add_checked_row(8'h00, pack_result(lfed_pkg::KIND_ACK, 8'h00, 16'd0, 8'h00, 8'h00,
                                       8'h00, 8'h00, 1'b0, 7'd0, 1'b0, 1'b1));
    // Bad sum on an empty frame.
    add_row(lfed_pkg::START_BYTE); add_row(8'h00); add_row(8'h00);
    add_checked_row(8'h01, pack_result(lfed_pkg::KIND_BADSUM, 8'h00, 16'd0, 8'h00, 8'h00,
                                       8'h00, 8'h00, 1'b0, 7'd0, 1'b0, 1'b1));
    // Acknowledge with all-ones command id and status.
    add_row(lfed_pkg::START_BYTE); add_row(8'h00); add_row(8'h03);
    add_row(lfed_pkg::OPC_ACK); add_row(8'hFF); add_row(8'hFF);
    add_checked_row(8'hFF, pack_result(lfed_pkg::KIND_ACK, 8'h00, 16'd3, 8'hFF, 8'hFF,
                                       8'h00, 8'h00, 1'b0, 7'd0, 1'b0, 1'b1));
    // LE event whose payload holds a start byte, taken as plain data.
    add_row(lfed_pkg::START_BYTE); add_row(8'h00); add_row(8'h05);
    add_row(lfed_pkg::OPC_LE_SIGNAL); add_row(8'h07); add_row(8'h00);
    add_row(lfed_pkg::START_BYTE); add_row(8'h01); add_row(8'h17);
    directed_rows = stim_rows.size();

    // Random frames; one fills the payload store exactly, one overflows it.
    frame_no = 0;
    while (stim_rows.size() < TOTAL_BYTES) begin
      if (frame_no == 3) add_random_frame(3 + PAY_DEPTH);
      else if (frame_no == 10) add_random_frame($urandom_range(4 + PAY_DEPTH, 11 + PAY_DEPTH));
      else add_random_frame(-1);
      frame_no++;
    end
    pause_row = directed_rows + (stim_rows.size() - directed_rows) / 2;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    burst_left = 0;
    for (int i = 0; i < stim_rows.size(); i++) begin
      if (i == directed_rows || i == pause_row) begin
        // Let every outstanding result drain before going on.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end else if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      in_valid_i <= 1'b1;
      rx_byte_i  <= stim_rows[i].rx;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      // The request was taken at this edge.
      accepted_bytes++;
      deframe_byte(stim_rows[i].rx);
      if (stim_rows[i].checked) pending_results.push_back(stim_rows[i].want);
      else foreach (new_results[k]) pending_results.push_back(new_results[k]);
      new_results.delete();
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lfed_pkg.sv
hw/rtl/lfed_ram.sv
hw/rtl/length_framed_event_deframer.sv
dv/length_framed_event_deframer_test.sv
